### hdl/sfcd_pkg.sv
// Shared constants and types for the sensor frame CRC decoder.
package sfcd_pkg;

  typedef logic [15:0] crc_t;
  typedef logic [2:0]  byte_pos_t;

  localparam crc_t CRC_INIT = 16'hFFFF;
  localparam crc_t CRC_POLY = 16'hA001;

  // Byte positions within the 8-byte response frame
  localparam byte_pos_t POS_HUM_HI  = 3'd2;
  localparam byte_pos_t POS_HUM_LO  = 3'd3;
  localparam byte_pos_t POS_TEMP_HI = 3'd4;
  localparam byte_pos_t POS_TEMP_LO = 3'd5;
  localparam byte_pos_t POS_CRC_LO  = 3'd6;
  localparam byte_pos_t POS_CRC_HI  = 3'd7;

  localparam int TEMP_MAG_W = 15;

endpackage

### hdl/sfcd_crc16_step.sv
// One-byte update of the reflected CRC-16 (poly 0xA001), purely combinational.
module sfcd_crc16_step (
  input  sfcd_pkg::crc_t crc_in,
  input  logic [7:0]     data_in,
  output sfcd_pkg::crc_t crc_out
);
  import sfcd_pkg::*;

  always_comb begin
    crc_t c;
    c = crc_in ^ {8'h00, data_in};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

### hdl/sensor_frame_crc_decoder_core.sv
// Top level: byte-stream decoder for the 8-byte humidity/temperature sensor response.
//
//  channel | dir | tdata (low bit up)                         | tuser
//  --------+-----+--------------------------------------------+-------------
//  in_     | in  | [7:0] data_byte                            | frame_start
//  out_    | out | [15:0] temperature_tenths, [31:16] humid.  | crc_ok
//
// One byte per clock. Each accepted byte updates the frame state in the same
// cycle; the CRC step is an unrolled 8-bit update between the frame registers.
// The eighth byte loads the result register, seen on out_ the next cycle.
// rst_n (sync, active low) clears position, CRC, captured words and readings.
// Bytes 0..6 are taken even while a result waits; only a frame's last byte
// stalls in_tready until the result register is free.
module sensor_frame_crc_decoder_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] frame_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [15:0] temperature_tenths, [31:16] humidity_tenths
  output logic        out_tuser   // [0] crc_ok
);
  import sfcd_pkg::*;

  // frame state
  byte_pos_t   pos_r, pos_nxt;
  crc_t        crc_r, crc_nxt;
  logic [15:0] hum_word_r, hum_word_nxt;
  logic [15:0] temp_word_r, temp_word_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;
  logic [15:0] held_temp_r, held_temp_nxt;
  logic [15:0] held_hum_r, held_hum_nxt;

  // result register
  logic        out_valid_r, out_valid_nxt;
  logic        out_ok_r, out_ok_nxt;
  logic [15:0] out_temp_r, out_temp_nxt;
  logic [15:0] out_hum_r, out_hum_nxt;

  byte_pos_t   cur_pos;
  crc_t        cur_crc;
  crc_t        crc_step;
  logic        is_last;
  logic        in_acc;
  logic        crc_match;
  logic [TEMP_MAG_W-1:0] temp_mag;
  logic [15:0] temp_2c;

  // frame_start restarts position and CRC before the byte is used
  assign cur_pos = in_tuser ? '0 : pos_r;
  assign cur_crc = in_tuser ? CRC_INIT : crc_r;
  assign is_last = (cur_pos == POS_CRC_HI);

  assign in_tready = !is_last || !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  sfcd_crc16_step u_crc (
    .crc_in  (cur_crc),
    .data_in (in_tdata),
    .crc_out (crc_step)
  );

  assign crc_match = ({in_tdata, crc_lo_r} == crc_r);

  // sign-magnitude to two's complement; minus zero falls out as zero
  assign temp_mag = temp_word_r[TEMP_MAG_W-1:0];
  assign temp_2c  = temp_word_r[15] ? 16'(-{1'b0, temp_mag}) : {1'b0, temp_mag};

  always_comb begin
    pos_nxt       = pos_r;
    crc_nxt       = crc_r;
    hum_word_nxt  = hum_word_r;
    temp_word_nxt = temp_word_r;
    crc_lo_nxt    = crc_lo_r;
    held_temp_nxt = held_temp_r;
    held_hum_nxt  = held_hum_r;
    out_ok_nxt    = out_ok_r;
    out_temp_nxt  = out_temp_r;
    out_hum_nxt   = out_hum_r;
    out_valid_nxt = out_valid_r && !out_tready;

    if (in_acc) begin
      pos_nxt = cur_pos + 3'd1;   // wraps to 0 after the last byte
      crc_nxt = (cur_pos < POS_CRC_LO) ? crc_step : cur_crc;

      unique case (cur_pos)
        POS_HUM_HI:  hum_word_nxt  = {in_tdata, hum_word_r[7:0]};
        POS_HUM_LO:  hum_word_nxt  = {hum_word_r[15:8], in_tdata};
        POS_TEMP_HI: temp_word_nxt = {in_tdata, temp_word_r[7:0]};
        POS_TEMP_LO: temp_word_nxt = {temp_word_r[15:8], in_tdata};
        POS_CRC_LO:  crc_lo_nxt    = in_tdata;
        POS_CRC_HI: begin
          crc_nxt = CRC_INIT;
          if (crc_match) begin
            held_temp_nxt = temp_2c;
            held_hum_nxt  = hum_word_r;
          end
          out_valid_nxt = 1'b1;
          out_ok_nxt    = crc_match;
          out_temp_nxt  = crc_match ? temp_2c : held_temp_r;
          out_hum_nxt   = crc_match ? hum_word_r : held_hum_r;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      crc_r       <= CRC_INIT;
      hum_word_r  <= '0;
      temp_word_r <= '0;
      crc_lo_r    <= '0;
      held_temp_r <= '0;
      held_hum_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      crc_r       <= crc_nxt;
      hum_word_r  <= hum_word_nxt;
      temp_word_r <= temp_word_nxt;
      crc_lo_r    <= crc_lo_nxt;
      held_temp_r <= held_temp_nxt;
      held_hum_r  <= held_hum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload of the result register, no reset
  always_ff @(posedge clk) begin
    out_ok_r   <= out_ok_nxt;
    out_temp_r <= out_temp_nxt;
    out_hum_r  <= out_hum_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_ok_r;
  assign out_tdata  = {out_hum_r, out_temp_r};

endmodule
